@@ sv/rational_fraction_alu_macros.svh @@
// assertion macros shared by the rational fraction alu
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

// same-cycle implication
`define RFA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rfa_pkg.sv @@
// types, constants and micro-program for the rational fraction alu
package rfa_pkg;

	localparam int W = 32;
	localparam int CNT_W = $clog2(W + 1);
	localparam int NREG = 8;
	localparam int RA_W = $clog2(NREG);
	localparam int LD_W = 2;
	localparam int PC_W = 6;

	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	localparam logic [LD_W-1:0] LD_LAST = 2'd3;

	// register file map
	localparam logic [RA_W-1:0] R_AN = 3'd0;
	localparam logic [RA_W-1:0] R_AD = 3'd1;
	localparam logic [RA_W-1:0] R_BN = 3'd2;
	localparam logic [RA_W-1:0] R_BD = 3'd3;
	localparam logic [RA_W-1:0] R_T0 = 3'd4;
	localparam logic [RA_W-1:0] R_T1 = 3'd5;
	localparam logic [RA_W-1:0] R_T2 = 3'd6;
	localparam logic [RA_W-1:0] R_T3 = 3'd7;

	localparam logic [PC_W-1:0] PC_ADD = 6'd0;
	localparam logic [PC_W-1:0] PC_SUB = 6'd11;
	localparam logic [PC_W-1:0] PC_MUL = 6'd22;
	localparam logic [PC_W-1:0] PC_DIV = 6'd34;
	localparam logic [PC_W-1:0] PC_RED = 6'd46;

	typedef struct packed {
		logic [2:0]          command;
		logic signed [W-1:0] a_num;
		logic signed [W-1:0] a_den;
		logic signed [W-1:0] b_num;
		logic signed [W-1:0] b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [W-1:0] res_num;
		logic signed [W-1:0] res_den;
		logic [1:0]          status;
	} out_word_t;

	typedef enum logic [3:0] {
		OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GCD, OP_TSTN, OP_TSTB, OP_NEGC
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [RA_W-1:0] rd;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
	} uop_t;

	typedef enum logic [2:0] {
		C_IDLE, C_LOAD, C_FETCH, C_EXEC, C_WAIT, C_CAPT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DP_IDLE, DP_DIV, DP_GCD_CHK, DP_GCD_DIV
	} dp_state_t;

	typedef struct packed {
		logic            load_in;
		logic            clr_flags;
		logic            wr_load;
		logic [LD_W-1:0] load_idx;
		logic            start;
		op_t             op;
		logic [RA_W-1:0] rd;
		logic [RA_W-1:0] ra;
		logic [RA_W-1:0] rb;
		logic            capture;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

	function automatic uop_t mk(input op_t op, input logic [RA_W-1:0] rd,
		input logic [RA_W-1:0] ra, input logic [RA_W-1:0] rb);
		uop_t u;
		u.op = op;
		u.rd = rd;
		u.ra = ra;
		u.rb = rb;
		return u;
	endfunction

	// end entries read numerator and denominator for the result
	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// add
			6'd0:  u = mk(OP_GCD,  R_T0, R_AD, R_BD);
			6'd1:  u = mk(OP_DIV,  R_T1, R_BD, R_T0);
			6'd2:  u = mk(OP_DIV,  R_T2, R_AD, R_T0);
			6'd3:  u = mk(OP_MUL,  R_T3, R_AN, R_T1);
			6'd4:  u = mk(OP_MUL,  R_T2, R_BN, R_T2);
			6'd5:  u = mk(OP_ADD,  R_AN, R_T3, R_T2);
			6'd6:  u = mk(OP_MUL,  R_AD, R_AD, R_T1);
			6'd7:  u = mk(OP_TSTN, R_AN, R_AD, R_AD);
			6'd8:  u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd9:  u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd10: u = mk(OP_END,  R_AN, R_AN, R_AD);
			// subtract
			6'd11: u = mk(OP_GCD,  R_T0, R_AD, R_BD);
			6'd12: u = mk(OP_DIV,  R_T1, R_BD, R_T0);
			6'd13: u = mk(OP_DIV,  R_T2, R_AD, R_T0);
			6'd14: u = mk(OP_MUL,  R_T3, R_AN, R_T1);
			6'd15: u = mk(OP_MUL,  R_T2, R_BN, R_T2);
			6'd16: u = mk(OP_SUB,  R_AN, R_T3, R_T2);
			6'd17: u = mk(OP_MUL,  R_AD, R_AD, R_T1);
			6'd18: u = mk(OP_TSTN, R_AN, R_AD, R_AD);
			6'd19: u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd20: u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd21: u = mk(OP_END,  R_AN, R_AN, R_AD);
			// multiply
			6'd22: u = mk(OP_GCD,  R_T0, R_AN, R_BD);
			6'd23: u = mk(OP_GCD,  R_T1, R_BN, R_AD);
			6'd24: u = mk(OP_DIV,  R_T2, R_AN, R_T0);
			6'd25: u = mk(OP_DIV,  R_T3, R_BN, R_T1);
			6'd26: u = mk(OP_DIV,  R_AD, R_AD, R_T1);
			6'd27: u = mk(OP_DIV,  R_BD, R_BD, R_T0);
			6'd28: u = mk(OP_MUL,  R_AN, R_T2, R_T3);
			6'd29: u = mk(OP_MUL,  R_AD, R_AD, R_BD);
			6'd30: u = mk(OP_TSTN, R_AN, R_AD, R_AD);
			6'd31: u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd32: u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd33: u = mk(OP_END,  R_AN, R_AN, R_AD);
			// divide
			6'd34: u = mk(OP_GCD,  R_T0, R_AN, R_BN);
			6'd35: u = mk(OP_GCD,  R_T1, R_BD, R_AD);
			6'd36: u = mk(OP_DIV,  R_T2, R_AN, R_T0);
			6'd37: u = mk(OP_DIV,  R_T3, R_BD, R_T1);
			6'd38: u = mk(OP_DIV,  R_AD, R_AD, R_T1);
			6'd39: u = mk(OP_DIV,  R_BN, R_BN, R_T0);
			6'd40: u = mk(OP_MUL,  R_AN, R_T2, R_T3);
			6'd41: u = mk(OP_MUL,  R_AD, R_AD, R_BN);
			6'd42: u = mk(OP_TSTN, R_AN, R_AD, R_AD);
			6'd43: u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd44: u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd45: u = mk(OP_END,  R_AN, R_AN, R_AD);
			// reduce
			6'd46: u = mk(OP_TSTB, R_AN, R_AN, R_AD);
			6'd47: u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd48: u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd49: u = mk(OP_GCD,  R_T0, R_AN, R_AD);
			6'd50: u = mk(OP_TSTN, R_AN, R_AD, R_AD);
			6'd51: u = mk(OP_NEGC, R_AN, R_AN, R_AN);
			6'd52: u = mk(OP_NEGC, R_AD, R_AD, R_AD);
			6'd53: u = mk(OP_DIV,  R_AN, R_AN, R_T0);
			6'd54: u = mk(OP_DIV,  R_AD, R_AD, R_T0);
			default: u = mk(OP_END, R_AN, R_AN, R_AD);
		endcase
		return u;
	endfunction

	// command bit 2 picks reduce
	function automatic logic [PC_W-1:0] start_pc(input logic [2:0] c);
		logic [PC_W-1:0] p;
		if (c[2]) begin
			p = PC_RED;
		end else begin
			case (c)
				CMD_ADD: p = PC_ADD;
				CMD_SUB: p = PC_SUB;
				CMD_MUL: p = PC_MUL;
				CMD_DIV: p = PC_DIV;
				default: p = PC_RED;
			endcase
		end
		return p;
	endfunction

endpackage

@@ sv/rfa_divider.sv @@
// iterative restoring unsigned divider, one quotient bit per cycle
module rfa_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [rfa_pkg::W-1:0] dividend,
	input  logic [rfa_pkg::W-1:0] divisor,
	output logic                  done,
	output logic [rfa_pkg::W-1:0] quo,
	output logic [rfa_pkg::W-1:0] rem
);
	import rfa_pkg::*;

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dr_q;
	logic [W:0]       shifted;
	logic [W:0]       trial;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dr_q  <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

@@ sv/rfa_datapath.sv @@
// register file, arithmetic, gcd loop and result register
module rfa_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  rfa_pkg::in_word_t  in_data,
	input  rfa_pkg::dp_cmd_t   cmd,
	output rfa_pkg::dp_sts_t   sts,
	output rfa_pkg::out_word_t res
);
	import rfa_pkg::*;

	logic [W-1:0]        mem_q [0:NREG-1];
	logic signed [W-1:0] rda_q;
	logic signed [W-1:0] rdb_q;
	in_word_t            in_q;
	out_word_t           res_q;
	logic signed [W-1:0] opa_q;
	logic signed [W-1:0] opb_q;
	logic [W-1:0]        x_q;
	logic [W-1:0]        y_q;
	logic                cond_q;
	logic                zero_q;
	logic                ovf_q;
	dp_state_t           dps_q;
	dp_state_t           dps_d;

	logic                we;
	logic [RA_W-1:0]     waddr;
	logic [W-1:0]        wdata;
	logic                done;
	logic                set_zero;
	logic                set_ovf;
	logic                div_start;
	logic [W-1:0]        div_nd;
	logic [W-1:0]        div_dr;
	logic                div_done;
	logic [W-1:0]        div_quo;
	logic [W-1:0]        div_rem;

	logic [W-1:0]          mag_a;
	logic [W-1:0]          mag_b;
	logic signed [W-1:0]   sum;
	logic signed [W-1:0]   diff;
	logic signed [2*W-1:0] prod;
	logic                  add_ovf;
	logic                  sub_ovf;
	logic                  mul_ovf;
	logic                  sdiff;
	logic [W-1:0]          ld_word;

	assign mag_a   = rda_q[W-1] ? W'(-rda_q) : W'(rda_q);
	assign mag_b   = rdb_q[W-1] ? W'(-rdb_q) : W'(rdb_q);
	assign sum     = rda_q + rdb_q;
	assign diff    = rda_q - rdb_q;
	assign prod    = rda_q * rdb_q;
	assign add_ovf = (rda_q[W-1] == rdb_q[W-1]) && (sum[W-1] != rda_q[W-1]);
	assign sub_ovf = (rda_q[W-1] != rdb_q[W-1]) && (diff[W-1] != rda_q[W-1]);
	// product fits only if the upper half is a sign extension
	assign mul_ovf = !((&prod[2*W-1:W-1]) || !(|prod[2*W-1:W-1]));
	assign sdiff   = opa_q[W-1] ^ opb_q[W-1];

	always_comb begin
		case (cmd.load_idx)
			2'd0:    ld_word = in_q.a_num;
			2'd1:    ld_word = in_q.a_den;
			2'd2:    ld_word = in_q.b_num;
			default: ld_word = in_q.b_den;
		endcase
	end

	rfa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_nd),
		.divisor  (div_dr),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		we        = 1'b0;
		waddr     = cmd.rd;
		wdata     = '0;
		done      = 1'b0;
		set_zero  = 1'b0;
		set_ovf   = 1'b0;
		div_start = 1'b0;
		div_nd    = x_q;
		div_dr    = y_q;
		dps_d     = dps_q;
		case (dps_q)
			DP_IDLE: begin
				if (cmd.start) begin
					case (cmd.op)
						OP_ADD: begin
							we      = 1'b1;
							wdata   = sum;
							set_ovf = add_ovf;
							done    = 1'b1;
						end
						OP_SUB: begin
							we      = 1'b1;
							wdata   = diff;
							set_ovf = sub_ovf;
							done    = 1'b1;
						end
						OP_MUL: begin
							we      = 1'b1;
							wdata   = prod[W-1:0];
							set_ovf = mul_ovf;
							done    = 1'b1;
						end
						OP_NEGC: begin
							we      = 1'b1;
							wdata   = cond_q ? W'(-rda_q) : W'(rda_q);
							set_ovf = cond_q && (rda_q == MINV);
							done    = 1'b1;
						end
						OP_DIV: begin
							if (rdb_q == '0) begin
								// divide by zero gives zero and carries on
								we       = 1'b1;
								set_zero = 1'b1;
								done     = 1'b1;
							end else begin
								div_start = 1'b1;
								div_nd    = mag_a;
								div_dr    = mag_b;
								dps_d     = DP_DIV;
							end
						end
						OP_GCD: begin
							dps_d = DP_GCD_CHK;
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			DP_DIV: begin
				if (div_done) begin
					we      = 1'b1;
					wdata   = sdiff ? W'(-div_quo) : div_quo;
					set_ovf = (opa_q == MINV) && (opb_q == '1);
					done    = 1'b1;
					dps_d   = DP_IDLE;
				end
			end
			DP_GCD_CHK: begin
				if (y_q == '0) begin
					we       = 1'b1;
					wdata    = x_q;
					set_zero = (x_q == '0);
					set_ovf  = (x_q == MINV);
					done     = 1'b1;
					dps_d    = DP_IDLE;
				end else begin
					div_start = 1'b1;
					dps_d     = DP_GCD_DIV;
				end
			end
			DP_GCD_DIV: begin
				if (div_done) begin
					dps_d = DP_GCD_CHK;
				end
			end
			default: begin
				dps_d = DP_IDLE;
			end
		endcase
		if (cmd.wr_load) begin
			we    = 1'b1;
			waddr = RA_W'(cmd.load_idx);
			wdata = ld_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dps_q  <= DP_IDLE;
			cond_q <= 1'b0;
			zero_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			dps_q <= dps_d;
			if (cmd.clr_flags) begin
				zero_q <= 1'b0;
				ovf_q  <= 1'b0;
			end else begin
				zero_q <= zero_q | set_zero;
				ovf_q  <= ovf_q | set_ovf;
			end
			if (cmd.start && cmd.op == OP_TSTN) begin
				cond_q <= rda_q[W-1];
			end else if (cmd.start && cmd.op == OP_TSTB) begin
				cond_q <= rda_q[W-1] & rdb_q[W-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rda_q <= mem_q[cmd.ra];
		rdb_q <= mem_q[cmd.rb];
		if (cmd.start) begin
			opa_q <= rda_q;
			opb_q <= rdb_q;
		end
		if (cmd.start && cmd.op == OP_GCD && dps_q == DP_IDLE) begin
			x_q <= mag_a;
			y_q <= mag_b;
		end else if (dps_q == DP_GCD_DIV && div_done) begin
			x_q <= y_q;
			y_q <= div_rem;
		end
		if (cmd.capture) begin
			res_q.res_num <= rda_q;
			res_q.res_den <= rdb_q;
			if (zero_q || rdb_q == '0) begin
				res_q.status <= ST_ZERO;
			end else if (ovf_q) begin
				res_q.status <= ST_OVF;
			end else begin
				res_q.status <= ST_OK;
			end
		end
	end

	assign sts.done = done;
	assign res      = res_q;

endmodule

@@ sv/rfa_ctrl.sv @@
// micro-program sequencer and handshake control
module rfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [2:0]       command,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output rfa_pkg::dp_cmd_t cmd,
	input  rfa_pkg::dp_sts_t sts
);
	import rfa_pkg::*;

	ctrl_state_t     st_q;
	ctrl_state_t     st_d;
	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [LD_W-1:0] ld_q;
	logic [LD_W-1:0] ld_d;
	logic            ov_q;
	logic            ov_d;
	uop_t            u;

	assign u = uop_rom(pc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			pc_q <= '0;
			ld_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			pc_q <= pc_d;
			ld_q <= ld_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		pc_d     = pc_q;
		ld_d     = ld_q;
		ov_d     = ov_q && !out_ready;
		cmd      = '0;
		cmd.op   = u.op;
		cmd.rd   = u.rd;
		cmd.ra   = u.ra;
		cmd.rb   = u.rb;
		in_ready = (st_q == C_IDLE);
		case (st_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.load_in   = 1'b1;
					cmd.clr_flags = 1'b1;
					pc_d          = start_pc(command);
					ld_d          = '0;
					st_d          = C_LOAD;
				end
			end
			C_LOAD: begin
				cmd.wr_load  = 1'b1;
				cmd.load_idx = ld_q;
				ld_d         = ld_q + LD_W'(1);
				if (ld_q == LD_LAST) begin
					st_d = C_FETCH;
				end
			end
			C_FETCH: begin
				// register file read happens on this edge
				st_d = (u.op == OP_END) ? C_CAPT : C_EXEC;
			end
			C_EXEC: begin
				cmd.start = 1'b1;
				if (sts.done) begin
					pc_d = pc_q + PC_W'(1);
					st_d = C_FETCH;
				end else begin
					st_d = C_WAIT;
				end
			end
			C_WAIT: begin
				if (sts.done) begin
					pc_d = pc_q + PC_W'(1);
					st_d = C_FETCH;
				end
			end
			C_CAPT: begin
				if (!ov_q || out_ready) begin
					cmd.capture = 1'b1;
					ov_d        = 1'b1;
					st_d        = C_IDLE;
				end
			end
			default: begin
				st_d = C_IDLE;
			end
		endcase
	end

	assign out_valid = ov_q;

endmodule

@@ sv/rational_fraction_alu.sv @@
// Rational fraction ALU: add, subtract, multiply or divide two signed 32-bit
// fractions, or reduce one, one word at a time. A micro-program steps through
// the command; each step is a register read followed by an execute. A divide
// step waits on the serial divider, and a gcd step runs one Euclid modulo
// step through it per iteration. Add and subtract cost one gcd, two divides
// and seven steps that finish without the divider; multiply and divide cost
// two gcds and four divides; reduce costs one gcd and two divides. A word is
// accepted, its four fields are loaded into the register file, the
// micro-program runs and the result is captured. The time a word takes is
// set by the number of modulo steps through the one shared divider; a zero
// divisor skips the serial divider. Input is refused while a word is in
// progress; the result register lets the next word be taken before the
// previous result has been read.
`include "rational_fraction_alu_macros.svh"

module rational_fraction_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rfa_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rfa_pkg::out_word_t out_data
);
	import rfa_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	rfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (in_data.command),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	rfa_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.cmd     (dp_cmd),
		.sts     (dp_sts),
		.res     (out_data)
	);

	`RFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word did not block input")
	`RFA_ASSERT_SAME(a_done_only_busy, dp_sts.done, !in_ready, "datapath finished a step while idle")
	`RFA_ASSERT_SAME(a_ok_den_positive, out_valid && out_data.status == ST_OK, !out_data.res_den[W-1] && out_data.res_den != '0, "ok result with non-positive denominator")

endmodule

@@ test/tb_rational_fraction_alu.sv @@
// testbench for the rational fraction alu: directed table, then random words checked against a predictor
`timescale 1ns / 100ps

module tb_rational_fraction_alu;
	import rfa_pkg::*;

	localparam int N_RANDOM = 1330;
	localparam longint LIMIT = 64'd30000000;
	localparam logic [2:0] CMD_RED = 3'd4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;

	int in_idle_pct = 27;
	int out_idle_pct = 59;
	bit hold_out = 1'b0;
	bit hold_taken = 1'b0;
	int hold_cycles = 0;
	int errors = 0;
	int n_words = 0;
	int n_results = 0;
	int n_status [4];
	longint cycle_count = 0;
	out_word_t fraction_q [$];

	always #1 clk = ~clk;

	rational_fraction_alu dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// arithmetic at 32 bits held sign-extended in 64
	bit fz, fo;

	function automatic longint sx32(input longint v);
		return longint'(int'(v));
	endfunction

	function automatic longint magn(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint f_neg(input longint v);
		if (v == -64'sd2147483648) fo = 1'b1;
		return sx32(-v);
	endfunction

	function automatic longint f_add(input longint a, input longint b);
		longint r;
		r = a + b;
		if (r != sx32(r)) fo = 1'b1;
		return sx32(r);
	endfunction

	function automatic longint f_sub(input longint a, input longint b);
		longint r;
		r = a - b;
		if (r != sx32(r)) fo = 1'b1;
		return sx32(r);
	endfunction

	function automatic longint f_mul(input longint a, input longint b);
		longint r;
		r = a * b;
		if (r != sx32(r)) fo = 1'b1;
		return sx32(r);
	endfunction

	function automatic longint f_div(input longint a, input longint b);
		longint q;
		if (b == 0) begin
			fz = 1'b1;
			return 0;
		end
		q = magn(a) / magn(b);
		if ((a < 0) != (b < 0)) q = -q;
		if (q != sx32(q)) fo = 1'b1;
		return sx32(q);
	endfunction

	function automatic longint f_gcd(input longint a, input longint b);
		longint x, y, t;
		x = magn(a);
		y = magn(b);
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		if (x == 0) fz = 1'b1;
		if (x == 64'sd2147483648) fo = 1'b1;
		return sx32(x);
	endfunction

	function automatic out_word_t predict_fraction(input in_word_t w);
		longint an, ad, bn, bd, n, d, g, c, e;
		out_word_t r;
		an = longint'(w.a_num);
		ad = longint'(w.a_den);
		bn = longint'(w.b_num);
		bd = longint'(w.b_den);
		fz = 1'b0;
		fo = 1'b0;
		if (w.command[2]) begin
			n = an;
			d = ad;
			if (n < 0 && d < 0) begin
				n = f_neg(n);
				d = f_neg(d);
			end
			g = f_gcd(n, d);
			if (d < 0) begin
				n = f_neg(n);
				d = f_neg(d);
			end
			n = f_div(n, g);
			d = f_div(d, g);
		end else begin
			if (w.command == CMD_ADD || w.command == CMD_SUB) begin
				g = f_gcd(ad, bd);
				c = f_div(bd, g);
				e = f_div(ad, g);
				if (w.command == CMD_ADD) n = f_add(f_mul(an, c), f_mul(bn, e));
				else n = f_sub(f_mul(an, c), f_mul(bn, e));
				d = f_mul(ad, c);
			end else if (w.command == CMD_MUL) begin
				c = f_gcd(an, bd);
				e = f_gcd(bn, ad);
				n = f_mul(f_div(an, c), f_div(bn, e));
				d = f_mul(f_div(ad, e), f_div(bd, c));
			end else begin
				c = f_gcd(an, bn);
				e = f_gcd(bd, ad);
				n = f_mul(f_div(an, c), f_div(bd, e));
				d = f_mul(f_div(ad, e), f_div(bn, c));
			end
			if (d < 0) begin
				n = f_neg(n);
				d = f_neg(d);
			end
		end
		r.res_num = n[31:0];
		r.res_den = d[31:0];
		r.status = (fz || d == 0) ? ST_ZERO : (fo ? ST_OVF : ST_OK);
		return r;
	endfunction

	task automatic send_word(input in_word_t w);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		fraction_q = {fraction_q, predict_fraction(w)};
		n_words++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (fraction_q.size() != 0);
	endtask

	// receiver side
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (hold_out && !hold_taken) begin
			hold_cycles <= 20000;
			hold_taken <= 1'b1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("%0t timeout", $time);
			$display("tb_rational_fraction_alu failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (fraction_q.size() == 0) begin
				$display("%0t unexpected word: %h", $time, out_data);
				errors++;
			end else begin
				out_word_t x;
				x = fraction_q.pop_front();
				n_results++;
				n_status[out_data.status]++;
				if (x.res_num !== out_data.res_num || x.res_den !== out_data.res_den
					|| x.status !== out_data.status) begin
					$display("%0t mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
						$time, x.res_num, x.res_den, x.status,
						out_data.res_num, out_data.res_den, out_data.status);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rand_field();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'(int'($urandom_range(40)) - 20);
			2: return $urandom_range(1, 1000);
			3: return 32'(-int'($urandom_range(1, 1000)));
			4: return ($urandom_range(1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return 32'($urandom_range(1, 60)) * 32'($urandom_range(1, 60));
		endcase
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		w.command = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		w.a_num = rand_field();
		w.a_den = rand_field();
		w.b_num = rand_field();
		w.b_den = rand_field();
		return w;
	endfunction

	typedef struct {
		in_word_t w;
		bit known;
		out_word_t r;
	} vec_t;

	vec_t vec [$];

	task automatic add_vec(input logic [2:0] c, input int an, input int ad, input int bn,
		input int bd, input bit known, input int rn, input int rd, input logic [1:0] st);
		vec_t v;
		v.w = '{c, an, ad, bn, bd};
		v.known = known;
		v.r = '{rn, rd, st};
		vec = {vec, v};
	endtask

	initial begin
		in_word_t w;
		add_vec(CMD_ADD, 1, 2, 1, 3, 1, 5, 6, ST_OK);
		add_vec(CMD_SUB, 1, 2, 1, 3, 1, 1, 6, ST_OK);
		add_vec(CMD_MUL, 2, 3, 3, 4, 1, 1, 2, ST_OK);
		add_vec(CMD_DIV, 2, 3, 4, 9, 1, 3, 2, ST_OK);
		add_vec(CMD_RED, 6, -4, 0, 0, 1, -3, 2, ST_OK);
		add_vec(CMD_RED, -6, -4, 0, 0, 1, 3, 2, ST_OK);
		add_vec(3'd5, 10, 4, 0, 0, 1, 5, 2, ST_OK);
		add_vec(3'd6, 0, 0, 0, 0, 1, 0, 0, ST_ZERO);
		add_vec(3'd7, 0, 7, 1, 1, 0, 0, 0, 0);
		add_vec(CMD_ADD, 1, 0, 1, 0, 1, 0, 0, ST_ZERO);
		add_vec(CMD_MUL, 0, 1, 0, 1, 0, 0, 0, 0);
		add_vec(CMD_DIV, 1, 2, 0, 3, 0, 0, 0, 0);
		add_vec(CMD_RED, 32'h8000_0000, 1, 0, 0, 0, 0, 0, 0);
		add_vec(CMD_RED, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0);
		add_vec(CMD_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 1, -2, 1, ST_OVF);
		add_vec(CMD_SUB, 32'h8000_0000, 1, 1, 1, 1, 32'h7fff_ffff, 1, ST_OVF);
		add_vec(CMD_MUL, 32'h7fff_ffff, 1, 2, 1, 0, 0, 0, 0);
		add_vec(CMD_DIV, 32'h8000_0000, 3, -1, 5, 0, 0, 0, 0);
		add_vec(CMD_ADD, 1, -3, 1, 5, 0, 0, 0, 0);
		add_vec(CMD_MUL, -1, 32'h8000_0000, 1, -1, 0, 0, 0, 0);
		add_vec(CMD_RED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1, ST_OK);
		add_vec(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (vec[i]) begin
			if (vec[i].known && predict_fraction(vec[i].w) != vec[i].r) begin
				$display("%0t table row %0d disagrees: expected %h, predicted %h",
					$time, i, vec[i].r, predict_fraction(vec[i].w));
				errors++;
			end
			send_word(vec[i].w);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) begin
				in_idle_pct = 59;
				out_idle_pct = 27;
			end else if (i == 2 * N_RANDOM / 3) begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			// long receiver stall while words keep coming
			if (i == 100) hold_out = 1'b1;
			if (i == 104) hold_out = 1'b0;
			// sender pause until everything is back
			if (i == 500) drain_results();
			w = rand_word();
			send_word(w);
		end

		drain_results();
		repeat (200) @(posedge clk);
		$display("%0d words sent, %0d results checked over all commands", n_words, n_results);
		$display("status counts: ok %0d, zero %0d, overflow %0d",
			n_status[0], n_status[1], n_status[2]);
		if (errors == 0 && fraction_q.size() == 0) begin
			$display("tb_rational_fraction_alu passed");
		end else begin
			$display("tb_rational_fraction_alu failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rfa_pkg.sv
sv/rfa_divider.sv
sv/rfa_datapath.sv
sv/rfa_ctrl.sv
sv/rational_fraction_alu.sv
test/tb_rational_fraction_alu.sv
